// ----- rtl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and fixed constants of the text console: field widths, command
// codes, special characters and the cell layout.
// ----------------------------------------------------------------------------
package tcs_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int LIN_W  = 11;
   localparam int CELL_W = 2 * BYTE_W;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0a;
   localparam logic [BYTE_W-1:0] TAB_CHAR     = 8'h09;
   localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h0f;

   typedef struct packed {
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] code;
   } cell_type;

endpackage

// ----- rtl/tcs_ram.sv -----
// ----------------------------------------------------------------------------
// tcs_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/text_console_cursor_scroll.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell text console: screen memory of ROWS x COLUMNS cells, a
// cursor, put / clear / read commands, scrolling through a rotating row base.
// ----------------------------------------------------------------------------
// Put without scroll and unused command: S_DONE registers the result.
// Read: S_READ takes the registered read of the screen RAM, then S_DONE.
// Put that scrolls: S_SWEEP blanks the new last row, one cell per cycle.
// Clear: S_SWEEP blanks every cell, one RAM write per cycle, then S_DONE.
// After reset the block blanks the whole screen in S_INIT and accepts no item
// meanwhile; attribute writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll import tcs_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BYTE_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_read_row,
   input  logic [COL_W-1:0]  req_read_col,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [LIN_W-1:0]  rsp_cursor_linear,
   output logic [BYTE_W-1:0] rsp_cell_char,
   output logic [BYTE_W-1:0] rsp_cell_attr,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(COLUMNS);
   localparam int PW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
   localparam int XW    = $clog2(COLUMNS + TAB_WIDTH + 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_SWEEP,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [RW-1:0]     base_ff, base_in;
   logic [AW-1:0]     sweep_addr_ff, sweep_addr_in;
   logic [AW-1:0]     sweep_last_ff, sweep_last_in;
   logic              in_range_ff, in_range_in;
   cell_type          res_cell_ff, res_cell_in;
   logic [BYTE_W-1:0] attr_ff, attr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [LIN_W-1:0]  rsp_lin_ff, rsp_lin_in;
   cell_type          rsp_cell_ff, rsp_cell_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   cell_type          ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   logic              out_free;
   logic              rd_ok;
   logic [XW-1:0]     col_sum;
   logic              row_adv;
   logic [AW-1:0]     scroll_start;

   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                              input logic [RW-1:0] row);
      logic [RW:0] sum;
      sum = {1'b0, base} + {1'b0, row};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                               input logic [CW-1:0] col);
      return AW'(AW'(prow * COLUMNS) + AW'(col));
   endfunction

   tcs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rd_ok        = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLUMNS);
   assign scroll_start = cell_addr(base_ff, CW'(0));

   always_comb begin
      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      phase_in      = phase_ff;
      base_in       = base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      in_range_in   = in_range_ff;
      res_cell_in   = res_cell_ff;
      attr_in       = csr_we ? csr_wdata : attr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_lin_in    = rsp_lin_ff;
      rsp_cell_in   = rsp_cell_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_addr_ff;
      ram_wr_data   = '{attr: attr_ff, code: BLANK_CHAR};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cell_addr(phys_row(base_ff, RW'(req_read_row)), CW'(req_read_col));
      col_sum       = XW'(cur_col_ff);
      row_adv       = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '{attr: RESET_ATTR, code: BLANK_CHAR};
            sweep_addr_in = sweep_addr_ff + AW'(1);
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_cell_in = '0;
               state_in    = S_DONE;
               unique case (req_cmd)
                  CMD_PUT: begin
                     if (req_char_code == NEWLINE_CHAR) begin
                        row_adv  = 1'b1;
                        col_sum  = '0;
                        phase_in = '0;
                     end else if (req_char_code == TAB_CHAR) begin
                        if (phase_ff != '0) begin
                           col_sum = XW'(cur_col_ff) + XW'(TAB_WIDTH) - XW'(phase_ff);
                        end
                        phase_in = '0;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cell_addr(phys_row(base_ff, cur_row_ff), cur_col_ff);
                        ram_wr_data = '{attr: attr_ff, code: req_char_code};
                        col_sum     = XW'(cur_col_ff) + XW'(1);
                        phase_in    = (phase_ff == PW'(TAB_WIDTH - 1)) ? '0 : phase_ff + PW'(1);
                     end
                     if (col_sum >= XW'(COLUMNS)) begin
                        col_sum  = '0;
                        row_adv  = 1'b1;
                        phase_in = '0;
                     end
                     cur_col_in = CW'(col_sum);
                     if (row_adv) begin
                        if (cur_row_ff == RW'(ROWS - 1)) begin
                           // scroll: oldest physical row becomes the blank last row
                           sweep_addr_in = scroll_start;
                           sweep_last_in = scroll_start + AW'(COLUMNS - 1);
                           base_in  = (base_ff == RW'(ROWS - 1)) ? '0 : base_ff + RW'(1);
                           state_in = S_SWEEP;
                        end else begin
                           cur_row_in = cur_row_ff + RW'(1);
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     cur_row_in    = '0;
                     cur_col_in    = '0;
                     phase_in      = '0;
                     base_in       = '0;
                     sweep_addr_in = '0;
                     sweep_last_in = AW'(DEPTH - 1);
                     state_in      = S_SWEEP;
                  end
                  CMD_READ: begin
                     ram_rd_en   = rd_ok;
                     in_range_in = rd_ok;
                     state_in    = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_cell_in = in_range_ff ? cell_type'(ram_rd_data) : '0;
            state_in    = S_DONE;
         end
         S_SWEEP: begin
            ram_wr_en     = 1'b1;
            sweep_addr_in = sweep_addr_ff + AW'(1);
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_W'(cur_row_ff);
               rsp_col_in   = COL_W'(cur_col_ff);
               rsp_lin_in   = LIN_W'(cur_row_ff * COLUMNS + cur_col_ff);
               rsp_cell_in  = res_cell_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         phase_ff      <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= AW'(DEPTH - 1);
         in_range_ff   <= 1'b0;
         attr_ff       <= RESET_ATTR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         phase_ff      <= phase_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         in_range_ff   <= in_range_in;
         attr_ff       <= attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      res_cell_ff <= res_cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_lin_ff  <= rsp_lin_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_cell_char     = rsp_cell_ff.code;
   assign rsp_cell_attr     = rsp_cell_ff.attr;

endmodule
